[rtl/rrt_nearest_and_steer_unit_assert.svh]
// assertion macros for the nearest-node and steer unit
`ifndef RRT_NEAREST_AND_STEER_UNIT_ASSERT_SVH
`define RRT_NEAREST_AND_STEER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/rns_pkg.sv]
// shared constants, types and helpers of the nearest-node and steer unit
`timescale 1ns / 1ps
package rns_pkg;
    localparam int MAX_NODES  = 4096;
    localparam int COORD_BITS = 10;
    localparam int IDX_BITS   = $clog2(MAX_NODES);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int PAR_BITS   = 12;
    localparam int STEP_BITS  = 10;
    localparam int D2_BITS    = 2 * COORD_BITS + 1;
    localparam int N_CELLS    = 4;
    localparam int CELL_BITS  = $clog2(N_CELLS);
    localparam int BANK_DEPTH = MAX_NODES / N_CELLS;
    localparam int BANK_BITS  = IDX_BITS - CELL_BITS;
    localparam int CMD_QUERY  = 0;
    localparam int CMD_INSERT = 1;
    localparam logic [1:0] REG_START_X = 2'd0;
    localparam logic [1:0] REG_START_Y = 2'd1;
    localparam logic [1:0] REG_STEP    = 2'd2;

    typedef struct packed {
        logic                  vld;
        logic [D2_BITS-1:0]    d2;
        logic [IDX_BITS-1:0]   idx;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [PAR_BITS-1:0]   par;
    } t_cand;

    typedef struct packed {
        logic                 clr;
        logic                 en;
        logic [BANK_BITS-1:0] addr;
    } t_scan;

    typedef struct packed {
        logic                  en;
        logic [IDX_BITS-1:0]   idx;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [PAR_BITS-1:0]   par;
    } t_wr;

    // closer candidate wins, lower index on a tie
    function automatic t_cand better(input t_cand a, input t_cand b);
        if (a.vld && (!b.vld || a.d2 < b.d2 || (a.d2 == b.d2 && a.idx < b.idx)))
            return a;
        return b;
    endfunction
endpackage

[rtl/rns_cell.sv]
// one scan cell: a bank of the node table, distance pipeline and running best
`timescale 1ns / 1ps
module rns_cell import rns_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CELL_BITS-1:0]  i_cell_id,
    input  t_scan                 i_scan,
    input  t_wr                   i_wr,
    input  logic [CNT_BITS-1:0]   i_count,
    input  logic [COORD_BITS-1:0] i_px,
    input  logic [COORD_BITS-1:0] i_py,
    input  logic [COORD_BITS-1:0] i_root_x,
    input  logic [COORD_BITS-1:0] i_root_y,
    input  t_cand                 i_chain,
    output t_cand                 o_chain
);
    localparam int ENTRY_BITS = 2 * COORD_BITS + PAR_BITS;

    logic [ENTRY_BITS-1:0] mem [BANK_DEPTH];
    logic [ENTRY_BITS-1:0] r_rd;
    logic                  r_s1_vld;
    logic [IDX_BITS-1:0]   r_s1_idx;
    t_cand                 r_s2;
    t_cand                 r_best;
    t_cand                 r_chain;

    logic [IDX_BITS-1:0]   n_idx;
    logic [COORD_BITS-1:0] n_x, n_y, n_ax, n_ay;
    logic [PAR_BITS-1:0]   n_par;
    logic [COORD_BITS:0]   n_ex, n_ey;
    t_cand                 n_s2;

    assign n_idx = {i_scan.addr, i_cell_id};

    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.idx[CELL_BITS-1:0] == i_cell_id) begin
            mem[i_wr.idx[IDX_BITS-1:CELL_BITS]] <= {i_wr.par, i_wr.y, i_wr.x};
        end
        r_rd     <= mem[i_scan.addr];
        r_s1_idx <= n_idx;
    end

    always_comb begin
        if (r_s1_idx == '0) begin
            n_x   = i_root_x;
            n_y   = i_root_y;
            n_par = '0;
        end else begin
            n_x   = r_rd[COORD_BITS-1:0];
            n_y   = r_rd[2*COORD_BITS-1:COORD_BITS];
            n_par = r_rd[ENTRY_BITS-1:2*COORD_BITS];
        end
        n_ex = {1'b0, i_px} - {1'b0, n_x};
        n_ey = {1'b0, i_py} - {1'b0, n_y};
        n_ax = n_ex[COORD_BITS] ? COORD_BITS'(-n_ex) : n_ex[COORD_BITS-1:0];
        n_ay = n_ey[COORD_BITS] ? COORD_BITS'(-n_ey) : n_ey[COORD_BITS-1:0];
        n_s2.vld = r_s1_vld;
        n_s2.d2  = D2_BITS'(n_ax * n_ax) + D2_BITS'(n_ay * n_ay);
        n_s2.idx = r_s1_idx;
        n_s2.x   = n_x;
        n_s2.y   = n_y;
        n_s2.par = n_par;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2.vld    <= 1'b0;
            r_best.vld  <= 1'b0;
            r_chain.vld <= 1'b0;
        end else begin
            r_s1_vld <= i_scan.en && ({1'b0, n_idx} < i_count);
            r_s2     <= n_s2;
            if (i_scan.clr) begin
                r_best.vld <= 1'b0;
            end else if (r_s2.vld && (!r_best.vld || r_s2.d2 < r_best.d2)) begin
                r_best <= r_s2;
            end
            r_chain <= better(i_chain, r_best);
        end
    end

    assign o_chain = r_chain;
endmodule

[rtl/rns_steer.sv]
// exact floor of d * s / sqrt(dd) by long division and bitwise square root
`timescale 1ns / 1ps
module rns_steer import rns_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [COORD_BITS:0]   i_d,
    input  logic [D2_BITS-1:0]           i_dd,
    input  logic [STEP_BITS-1:0]         i_s,
    output logic                         o_done,
    output logic signed [COORD_BITS:0]   o_val
);
    localparam int NUM_BITS = 4 * COORD_BITS;
    localparam int Q_BITS   = 2 * COORD_BITS;
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL1 = 3'd1;
    localparam logic [2:0] ST_MUL2 = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]              r_state;
    logic                    r_done;
    logic                    r_neg;
    logic [COORD_BITS-1:0]   r_a;
    logic [STEP_BITS-1:0]    r_s;
    logic [D2_BITS-1:0]      r_dd;
    logic [Q_BITS-1:0]       r_as;
    logic [NUM_BITS-1:0]     r_num;
    logic [D2_BITS-1:0]      r_rem;
    logic [Q_BITS-1:0]       r_q;
    logic [5:0]              r_cnt;
    logic [COORD_BITS-1:0]   r_root;
    logic signed [COORD_BITS:0] r_val;

    logic [D2_BITS:0]        n_rem;
    logic                    n_qbit;
    logic [COORD_BITS-1:0]   n_trial;
    logic                    n_exact;
    logic [COORD_BITS:0]     n_mag;

    always_comb begin
        n_rem  = {r_rem, r_num[NUM_BITS-1]};
        n_qbit = n_rem >= {1'b0, r_dd};
        if (n_qbit) n_rem = n_rem - {1'b0, r_dd};
        n_trial = r_root | (COORD_BITS'(1) << r_cnt[3:0]);
        n_exact = (Q_BITS'(r_root * r_root) == r_q) && (r_rem == '0);
        n_mag   = {1'b0, r_root} + (COORD_BITS+1)'(!n_exact);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_d[COORD_BITS];
                        r_a     <= i_d[COORD_BITS] ? COORD_BITS'(-i_d) : i_d[COORD_BITS-1:0];
                        r_s     <= i_s;
                        r_dd    <= i_dd;
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_root  <= '0;
                        r_state <= (i_s == '0) ? ST_FIN : ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    r_as    <= Q_BITS'(r_a * r_s);
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_num   <= NUM_BITS'(r_as * r_as);
                    r_cnt   <= 6'(NUM_BITS - 1);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= n_rem[D2_BITS-1:0];
                    r_num <= {r_num[NUM_BITS-2:0], 1'b0};
                    r_q   <= {r_q[Q_BITS-2:0], n_qbit};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_cnt   <= 6'(COORD_BITS - 1);
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (Q_BITS'(n_trial * n_trial) <= r_q) r_root <= n_trial;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == '0) r_state <= ST_FIN;
                end
                ST_FIN: begin
                    r_val   <= r_neg ? -$signed(n_mag) : $signed({1'b0, r_root});
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_val  = r_val;
endmodule

[rtl/rrt_nearest_and_steer_unit.sv]
// top level: node table scan chain, steer unit, stream and config ports
// usage
//   slave stream takes one item: tuser is the command (0 query, 1 insert),
//   tdata carries point_x, point_y and parent_index
//   master stream returns one item per input item with the nearest node,
//   the steered point and the insert status
//   config channel writes start_x (0), start_y (1), step_length (2); the user must do so only while idle (not enforced)
// operation
//   insert: the result passes through ST_RES into the output register
//   query: in ST_SCAN the four cells each read one bank entry per cycle,
//   then ST_DRAIN lets the cell chain drain;
//   when the sample is at or beyond the step, the x and then the y offset
//   go to the shared divide and square root unit
//   one item is in work at a time; a new item is taken once the previous
//   result sits in the output register
// reset
//   node table holds only the root at (40, 40), step length 30
//   a stalled receiver holds the output register; the block finishes the
//   next item and waits with it until the output register frees up
`timescale 1ns / 1ps
`include "rrt_nearest_and_steer_unit_assert.svh"
module rrt_nearest_and_steer_unit import rns_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // point_x[9:0], point_y[19:10], parent_index[31:20]
    input  logic [31:0] i_s_axis_tdata,
    // command
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // nearest_index[11:0], nearest_x[21:12], nearest_y[31:22],
    // nearest_parent[43:32], steered_x[53:44], steered_y[63:54],
    // within_step[64], new_index[76:65], table_full[77]
    output logic [79:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_PICK  = 3'd3;
    localparam logic [2:0] ST_SX    = 3'd4;
    localparam logic [2:0] ST_SY    = 3'd5;
    localparam logic [2:0] ST_RES   = 3'd6;
    localparam int DRAIN_CYC = 3 + N_CELLS + 2;

    logic [2:0]            r_state;
    logic                  r_cmd;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic [CNT_BITS-1:0]   r_count;
    logic [BANK_BITS-1:0]  r_addr;
    logic [3:0]            r_wait;
    t_cand                 r_nearest;
    logic [COORD_BITS-1:0] r_sx, r_sy;
    logic                  r_within;
    logic [IDX_BITS-1:0]   r_new_index;
    logic                  r_full;
    logic [79:0]           r_out;
    logic                  r_out_vld;
    logic [COORD_BITS-1:0] r_start_x, r_start_y;
    logic [STEP_BITS-1:0]  r_step;

    logic                  n_acc;
    logic [CNT_BITS-1:0]   n_count_m1;
    t_scan                 n_scan;
    t_wr                   n_wr;
    t_cand                 w_chain [N_CELLS+1];
    logic                  n_within;
    logic                  n_st_start;
    logic signed [COORD_BITS:0] n_st_d;
    logic                  w_st_done;
    logic signed [COORD_BITS:0] w_st_val;
    logic [COORD_BITS-1:0] n_steered;
    logic [79:0]           n_out;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign n_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign n_count_m1      = r_count - CNT_BITS'(1);

    always_comb begin
        n_scan.clr  = n_acc && (i_s_axis_tuser == 1'(CMD_QUERY));
        n_scan.en   = (r_state == ST_SCAN);
        n_scan.addr = r_addr;
        n_wr.en     = n_acc && (i_s_axis_tuser == 1'(CMD_INSERT))
                      && (r_count < CNT_BITS'(MAX_NODES));
        n_wr.idx    = r_count[IDX_BITS-1:0];
        n_wr.x      = i_s_axis_tdata[9:0];
        n_wr.y      = i_s_axis_tdata[19:10];
        n_wr.par    = i_s_axis_tdata[31:20];
    end

    assign w_chain[0] = '0;

    genvar c;
    generate
        for (c = 0; c < N_CELLS; c++) begin : g_cell
            rns_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_cell_id(CELL_BITS'(c)),
                .i_scan   (n_scan),
                .i_wr     (n_wr),
                .i_count  (r_count),
                .i_px     (r_px),
                .i_py     (r_py),
                .i_root_x (r_start_x),
                .i_root_y (r_start_y),
                .i_chain  (w_chain[c]),
                .o_chain  (w_chain[c+1])
            );
        end
    endgenerate

    assign n_within   = r_nearest.d2 < D2_BITS'(r_step * r_step);
    assign n_st_start = ((r_state == ST_PICK) && !n_within) ||
                        ((r_state == ST_SX) && w_st_done);
    assign n_st_d = (r_state == ST_PICK) ?
                    $signed({1'b0, r_px} - {1'b0, r_nearest.x}) :
                    $signed({1'b0, r_py} - {1'b0, r_nearest.y});
    assign n_steered = (r_state == ST_SX) ?
                       COORD_BITS'({1'b0, r_nearest.x} + w_st_val) :
                       COORD_BITS'({1'b0, r_nearest.y} + w_st_val);

    rns_steer u_steer (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(n_st_start),
        .i_d    (n_st_d),
        .i_dd   (r_nearest.d2),
        .i_s    (r_step),
        .o_done (w_st_done),
        .o_val  (w_st_val)
    );

    always_comb begin
        n_out = '0;
        if (r_cmd == 1'(CMD_INSERT)) begin
            n_out[76:65] = r_new_index;
            n_out[77]    = r_full;
        end else begin
            n_out[11:0]  = r_nearest.idx;
            n_out[21:12] = r_nearest.x;
            n_out[31:22] = r_nearest.y;
            n_out[43:32] = r_nearest.par;
            n_out[53:44] = r_sx;
            n_out[63:54] = r_sy;
            n_out[64]    = r_within;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= CNT_BITS'(1);
            r_out_vld <= 1'b0;
            r_start_x <= COORD_BITS'(40);
            r_start_y <= COORD_BITS'(40);
            r_step    <= STEP_BITS'(30);
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_START_X: r_start_x <= i_cfg_data;
                    REG_START_Y: r_start_y <= i_cfg_data;
                    REG_STEP:    r_step    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_m_axis_tvalid && i_m_axis_tready) r_out_vld <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (n_acc) begin
                        r_cmd  <= i_s_axis_tuser;
                        r_px   <= i_s_axis_tdata[9:0];
                        r_py   <= i_s_axis_tdata[19:10];
                        r_addr <= '0;
                        if (i_s_axis_tuser == 1'(CMD_INSERT)) begin
                            r_full      <= !n_wr.en;
                            r_new_index <= n_wr.en ? r_count[IDX_BITS-1:0] : '0;
                            if (n_wr.en) r_count <= r_count + CNT_BITS'(1);
                            r_state <= ST_RES;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_addr <= r_addr + BANK_BITS'(1);
                    if (r_addr == n_count_m1[IDX_BITS-1:CELL_BITS]) begin
                        r_wait  <= '0;
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_wait <= r_wait + 4'd1;
                    if (r_wait == 4'(DRAIN_CYC)) begin
                        r_nearest <= w_chain[N_CELLS];
                        r_state   <= ST_PICK;
                    end
                end
                ST_PICK: begin
                    if (n_within) begin
                        r_within <= 1'b1;
                        r_sx     <= r_px;
                        r_sy     <= r_py;
                        r_state  <= ST_RES;
                    end else begin
                        r_within <= 1'b0;
                        r_state  <= ST_SX;
                    end
                end
                ST_SX: begin
                    if (w_st_done) begin
                        r_sx    <= n_steered;
                        r_state <= ST_SY;
                    end
                end
                ST_SY: begin
                    if (w_st_done) begin
                        r_sy    <= n_steered;
                        r_state <= ST_RES;
                    end
                end
                ST_RES: begin
                    if (!r_out_vld || i_m_axis_tready) begin
                        r_out     <= n_out;
                        r_out_vld <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n,
        (r_count >= CNT_BITS'(1)) && (r_count <= CNT_BITS'(MAX_NODES)))
    `ASSERT_IMPLIES(a_full_only_when_full, i_clk, i_rst_n,
        (o_m_axis_tvalid && o_m_axis_tdata[77]), (r_count == CNT_BITS'(MAX_NODES)))
    `ASSERT_IMPLIES(a_nearest_found, i_clk, i_rst_n, (r_state == ST_PICK), r_nearest.vld)
endmodule

[tb/sv/testbench.sv]
// self-checking testbench of the nearest-node and steer unit with a table-driven predictor
`timescale 1ns / 1ps
module testbench import rns_pkg::*; ();
    localparam logic [1:0] REG_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0]  pad;
        logic        table_full;
        logic [11:0] new_index;
        logic        within_step;
        logic [9:0]  steered_y;
        logic [9:0]  steered_x;
        logic [11:0] nearest_parent;
        logic [9:0]  nearest_y;
        logic [9:0]  nearest_x;
        logic [11:0] nearest_index;
    } t_node_result;

    typedef struct {
        bit           cmd;
        logic [9:0]   x;
        logic [9:0]   y;
        logic [11:0]  par;
        bit           typed;
        t_node_result res;
    } t_tree_op;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_axis_tvalid = 0;
    logic [31:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 0;
    logic        i_m_axis_tready = 0;
    logic        i_cfg_valid = 0;
    logic [1:0]  i_cfg_index = '0;
    logic [9:0]  i_cfg_data = '0;
    logic        o_s_axis_tready, o_m_axis_tvalid, o_cfg_ready;
    logic [79:0] o_m_axis_tdata;

    rrt_nearest_and_steer_unit dut (.*);

    always #5 i_clk = ~i_clk;

    logic [9:0]   tree_x [MAX_NODES];
    logic [9:0]   tree_y [MAX_NODES];
    logic [11:0]  tree_par [MAX_NODES];
    int           tree_count;
    int           step_len;
    t_node_result steer_q[$];
    t_tree_op     directed_ops[$];
    int           errors = 0;
    int           src_idle = 0, snk_idle = 0, hold_cycles = 0;

    // exact floor of d * s / sqrt(dd)
    function automatic longint steer_offset(longint d, longint unsigned dd, longint unsigned s);
        longint unsigned a, target, lo, hi, mid;
        a = (d < 0) ? -d : d;
        target = a * a * s * s;
        lo = 0;
        hi = (s < a) ? s : a;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid * dd <= target) lo = mid;
            else hi = mid - 1;
        end
        if (d >= 0) return longint'(lo);
        return -longint'(lo + ((lo * lo * dd != target) ? 1 : 0));
    endfunction

    function automatic t_node_result predict_result(t_tree_op op);
        t_node_result r;
        int best;
        longint ex, ey, d2, best_d, sx, sy;
        longint unsigned s;
        r = '0;
        if (op.cmd == 1'(CMD_INSERT)) begin
            if (tree_count < MAX_NODES) begin
                tree_x[tree_count] = op.x;
                tree_y[tree_count] = op.y;
                tree_par[tree_count] = op.par;
                r.new_index = 12'(tree_count);
                tree_count++;
            end else begin
                r.table_full = 1'b1;
            end
            return r;
        end
        best = 0;
        best_d = 0;
        for (int i = 0; i < tree_count; i++) begin
            ex = longint'(op.x) - longint'(tree_x[i]);
            ey = longint'(op.y) - longint'(tree_y[i]);
            d2 = ex * ex + ey * ey;
            if (i == 0 || d2 < best_d) begin
                best = i;
                best_d = d2;
            end
        end
        s = longint'(step_len);
        if (best_d < s * s) begin
            sx = longint'(op.x);
            sy = longint'(op.y);
            r.within_step = 1'b1;
        end else begin
            sx = longint'(tree_x[best]) + steer_offset(longint'(op.x) - longint'(tree_x[best]),
                                                       best_d, s);
            sy = longint'(tree_y[best]) + steer_offset(longint'(op.y) - longint'(tree_y[best]),
                                                       best_d, s);
        end
        r.nearest_index = 12'(best);
        r.nearest_x = tree_x[best];
        r.nearest_y = tree_y[best];
        r.nearest_parent = tree_par[best];
        r.steered_x = 10'(sx);
        r.steered_y = 10'(sy);
        return r;
    endfunction

    task automatic cfg_write(logic [1:0] idx, logic [9:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_START_X) tree_x[0] = val;
        else if (idx == REG_START_Y) tree_y[0] = val;
        else if (idx == REG_STEP) step_len = int'(val);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic send_op(t_tree_op op);
        t_node_result r;
        while ($urandom_range(99) < src_idle) begin
            i_s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tuser <= op.cmd;
        i_s_axis_tdata <= {op.par, op.y, op.x};
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = predict_result(op);
        steer_q = {steer_q, (op.typed ? op.res : r)};
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 0;
        while (steer_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic t_tree_op random_op();
        t_tree_op op;
        int k, dx, dy;
        op.typed = 0;
        op.res = '0;
        op.cmd = ($urandom_range(99) < 40);
        op.x = 10'($urandom);
        op.y = 10'($urandom);
        op.par = 12'($urandom);
        case ($urandom_range(9))
            0: op.x = $urandom_range(1) ? 10'h3ff : 10'h000;
            1: op.y = $urandom_range(1) ? 10'h3ff : 10'h000;
            2, 3, 4: begin
                k = int'($urandom_range(tree_count - 1));
                dx = int'(tree_x[k]) + int'($urandom_range(80)) - 40;
                dy = int'(tree_y[k]) + int'($urandom_range(80)) - 40;
                op.x = 10'((dx < 0) ? 0 : (dx > 1023) ? 1023 : dx);
                op.y = 10'((dy < 0) ? 0 : (dy > 1023) ? 1023 : dy);
            end
            default: ;
        endcase
        return op;
    endfunction

    task automatic add_op(bit cmd, int x, int y, int par);
        t_tree_op op;
        op = '{cmd, 10'(x), 10'(y), 12'(par), 1'b0, '0};
        directed_ops = {directed_ops, op};
    endtask

    task automatic add_typed(bit cmd, int x, int y, int par, t_node_result r);
        t_tree_op op;
        op = '{cmd, 10'(x), 10'(y), 12'(par), 1'b1, r};
        directed_ops = {directed_ops, op};
    endtask

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_m_axis_tready <= 0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= snk_idle);
        end
    end

    always @(posedge i_clk) begin
        t_node_result e, a;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            a = o_m_axis_tdata;
            if (steer_q.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
            end else begin
                e = steer_q.pop_front();
                check_field("nearest_index", e.nearest_index, a.nearest_index);
                check_field("nearest_x", e.nearest_x, a.nearest_x);
                check_field("nearest_y", e.nearest_y, a.nearest_y);
                check_field("nearest_parent", e.nearest_parent, a.nearest_parent);
                check_field("steered_x", e.steered_x, a.steered_x);
                check_field("steered_y", e.steered_y, a.steered_y);
                check_field("within_step", e.within_step, a.within_step);
                check_field("new_index", e.new_index, a.new_index);
                check_field("table_full", e.table_full, a.table_full);
            end
        end
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_node_result r;
        tree_count = 1;
        step_len = 30;
        tree_x[0] = 40;
        tree_y[0] = 40;
        tree_par[0] = 0;
        src_idle = 38;
        snk_idle = 75;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // root only, default step
        r = '0; r.nearest_x = 40; r.nearest_y = 40; r.steered_x = 40; r.steered_y = 40;
        r.within_step = 1;
        add_typed(1'(CMD_QUERY), 40, 40, 4095, r);
        r = '0; r.new_index = 1;
        add_typed(1'(CMD_INSERT), 1023, 1023, 4095, r);
        r = '0; r.new_index = 2;
        add_typed(1'(CMD_INSERT), 0, 0, 0, r);
        r = '0; r.nearest_index = 2; r.within_step = 1;
        add_typed(1'(CMD_QUERY), 0, 0, 0, r);
        r = '0; r.nearest_index = 1; r.nearest_x = 1023; r.nearest_y = 1023;
        r.nearest_parent = 4095; r.steered_x = 1023; r.steered_y = 1023; r.within_step = 1;
        add_typed(1'(CMD_QUERY), 1023, 1023, 0, r);
        add_op(1'(CMD_QUERY), 1023, 0, 0);
        add_op(1'(CMD_QUERY), 0, 1023, 4095);
        add_op(1'(CMD_INSERT), 500, 500, 4000);
        add_op(1'(CMD_INSERT), 500, 500, 7);
        // equal distance: lower index wins
        r = '0; r.nearest_index = 3; r.nearest_x = 500; r.nearest_y = 500;
        r.nearest_parent = 4000; r.steered_x = 500; r.steered_y = 500; r.within_step = 1;
        add_typed(1'(CMD_QUERY), 500, 500, 0, r);
        r.steered_x = 530; r.within_step = 0;
        add_typed(1'(CMD_QUERY), 600, 500, 0, r);
        r.steered_x = 470;
        add_typed(1'(CMD_QUERY), 400, 500, 0, r);
        r.steered_x = 530;
        add_typed(1'(CMD_QUERY), 530, 500, 0, r);
        add_op(1'(CMD_QUERY), 533, 541, 0);
        add_op(1'(CMD_QUERY), 467, 459, 0);
        add_op(1'(CMD_QUERY), 700, 100, 0);
        add_op(1'(CMD_INSERT), 341, 682, 2730);
        add_op(1'(CMD_INSERT), 682, 341, 1365);
        add_op(1'(CMD_QUERY), 300, 900, 0);
        foreach (directed_ops[i]) send_op(directed_ops[i]);
        wait_idle();

        // zero step, root moved to a corner, unknown register ignored
        cfg_write(REG_STEP, 10'd0);
        cfg_write(REG_START_X, 10'd1023);
        cfg_write(REG_START_Y, 10'd0);
        cfg_write(REG_UNKNOWN, 10'd555);
        repeat (30) send_op(random_op());
        wait_idle();

        cfg_write(REG_STEP, 10'd1023);
        cfg_write(REG_START_X, 10'd0);
        cfg_write(REG_START_Y, 10'd1023);
        src_idle = 75;
        snk_idle = 38;
        repeat (30) send_op(random_op());
        wait_idle();

        cfg_write(REG_STEP, 10'($urandom_range(1, 60)));
        cfg_write(REG_START_X, 10'($urandom));
        cfg_write(REG_START_Y, 10'($urandom));
        src_idle = 0;
        snk_idle = 0;
        hold_cycles = 400;
        repeat (30) send_op(random_op());
        wait_idle();
        repeat (30) send_op(random_op());
        wait_idle();
        repeat (200) @(negedge i_clk);

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
